>>> rtl/hpt_pkg.sv
// ---------------------------------------------------------------------------
// hpt_pkg: shared types and constants for the hashed page table
// Entry layout, operation and status codes, controller states and the
// width of the head slot hash key.
// ---------------------------------------------------------------------------
package hpt_pkg;

    // default table size (head area plus overflow area)
    localparam int TABLE_SLOTS_DEF = 1024;

    // field widths
    localparam int ASID_W  = 8;
    localparam int VADDR_W = 32;
    localparam int PAGE_W  = 20;
    localparam int STAT_W  = 2;

    // hash key is asid xor vpage
    localparam int KEY_W = PAGE_W;

    // operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    // fixed part of a table entry; the link follows it in the memory word
    typedef struct packed {
        logic              valid;
        logic [ASID_W-1:0] asid;
        logic [PAGE_W-1:0] vpage;
        logic [PAGE_W-1:0] frame;
    } t_entry_fix;

    localparam int FIX_W = $bits(t_entry_fix);

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_CHECK,
        S_LINK,
        S_DONE
    } t_state;

endpackage

>>> rtl/hpt_hash.sv
// ---------------------------------------------------------------------------
// hpt_head_index: head slot reduction
// Computes key mod HEAD_SLOTS by reciprocal multiplication: estimate the
// quotient, subtract quotient times HEAD_SLOTS, then one conditional
// correction, each registered; o_done pulses with the result.
// ---------------------------------------------------------------------------
module hpt_head_index #(
    parameter int HEAD_SLOTS = hpt_pkg::TABLE_SLOTS_DEF / 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [hpt_pkg::KEY_W-1:0]         i_key,
    output logic                              o_done,
    output logic [$clog2(HEAD_SLOTS)-1:0]     o_rem
);
    import hpt_pkg::*;

    localparam int HW    = $clog2(HEAD_SLOTS);
    localparam int SHIFT = KEY_W + HW;
    localparam int RW    = KEY_W + 1;
    localparam int PW    = KEY_W + RW;
    // floor(2^SHIFT / HEAD_SLOTS): quotient estimate is low by at most one
    localparam logic [RW-1:0]    RECIP = RW'((longint'(1) << SHIFT) / longint'(HEAD_SLOTS));
    localparam logic [KEY_W-1:0] DIV_C = KEY_W'(HEAD_SLOTS);
    localparam logic [HW:0]      MOD_C = (HW+1)'(HEAD_SLOTS);

    logic [3:0]        r_vld;
    logic [KEY_W-1:0]  r_key;
    logic [PW-1:0]     r_prod;
    logic [HW:0]       r_part;
    logic [HW-1:0]     r_rem;
    logic [KEY_W-1:0]  quot;
    logic [KEY_W-1:0]  diff;

    // quotient estimate and partial remainder, which lies below 2*HEAD_SLOTS
    assign quot = KEY_W'(r_prod >> SHIFT);
    assign diff = r_key - quot * DIV_C;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_start};
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_key <= i_key;
        end
        if (r_vld[0]) begin
            r_prod <= PW'(r_key) * PW'(RECIP);
        end
        if (r_vld[1]) begin
            r_part <= diff[HW:0];
        end
        if (r_vld[2]) begin
            r_rem <= (r_part >= MOD_C) ? HW'(r_part - MOD_C) : r_part[HW-1:0];
        end
    end

    assign o_done = r_vld[3];
    assign o_rem  = r_rem;

endmodule

>>> rtl/hpt_mem.sv
// ---------------------------------------------------------------------------
// hpt_mem: entry table storage
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data valid in the cycle after the read enable.
// ---------------------------------------------------------------------------
module hpt_mem #(
    parameter int DEPTH = hpt_pkg::TABLE_SLOTS_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = 60
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/hashed_page_table_chained.sv
// Sequence: an accepted request is hashed, then the chain is walked with one
//   read per entry; an overflow insert ends with a link write to the tail.
// Only one transaction at a time: a new request is accepted only once the
//   last result has been taken into the output register.
// Reset: a clearing pass writes the TABLE_SLOTS/2 head slots, one per cycle,
//   with input stalled; overflow slots are tracked by a fill count.
// ---------------------------------------------------------------------------
// hashed_page_table_chained: hashed page table with collision chains
// Lookup walks the chain from the hashed head slot; insert fills an empty
// head or appends the next free overflow slot to the tail (ST_FULL if none).
// ---------------------------------------------------------------------------
module hashed_page_table_chained #(
    parameter int TABLE_SLOTS = hpt_pkg::TABLE_SLOTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_operation,
    input  logic [hpt_pkg::ASID_W-1:0]        i_space_id,
    input  logic [hpt_pkg::VADDR_W-1:0]       i_virt_addr,
    input  logic [hpt_pkg::PAGE_W-1:0]        i_new_frame,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [hpt_pkg::STAT_W-1:0]        o_status,
    output logic [hpt_pkg::PAGE_W-1:0]        o_virt_page,
    output logic [hpt_pkg::PAGE_W-1:0]        o_phys_frame
);
    import hpt_pkg::*;

    localparam int HEAD_SLOTS = TABLE_SLOTS / 2;
    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int HW = $clog2(HEAD_SLOTS);
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int EW = FIX_W + 1 + IW;
    localparam logic [HW-1:0] CLR_LAST = HW'(HEAD_SLOTS - 1);
    localparam logic [CW-1:0] OVF_BASE = CW'(HEAD_SLOTS);
    localparam logic [CW-1:0] OVF_END  = CW'(TABLE_SLOTS);

    t_state            r_state, n_state;
    logic [HW-1:0]     r_clr;
    logic [CW-1:0]     r_ovf;

    // latched request
    logic              r_op;
    logic [ASID_W-1:0] r_asid;
    logic [PAGE_W-1:0] r_vpage;
    logic [PAGE_W-1:0] r_frame;

    // walk state
    logic [IW-1:0]     r_cur;
    logic              r_first;
    t_entry_fix        r_tail_fix;
    t_status           r_res_status;
    logic [PAGE_W-1:0] r_res_frame;

    // output register
    logic              r_out_valid;
    t_status           r_out_status;
    logic [PAGE_W-1:0] r_out_vpage;
    logic [PAGE_W-1:0] r_out_frame;

    // memory ports
    logic              wr_en, rd_en;
    logic [IW-1:0]     wr_addr, rd_addr;
    logic [EW-1:0]     wr_data, rd_data;

    // hash unit
    logic              hash_done;
    logic [HW-1:0]     hash_rem;
    logic [KEY_W-1:0]  hash_key;

    // decoded entry from the read port
    t_entry_fix        e_fix;
    logic              e_has_link;
    logic [IW-1:0]     e_link;
    logic              e_match;
    logic              in_accept;
    logic              out_free;
    logic              ovf_full;
    t_entry_fix        new_fix;

    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign ovf_full   = (r_ovf == OVF_END);

    assign e_fix      = t_entry_fix'(rd_data[EW-1 -: FIX_W]);
    assign e_has_link = rd_data[IW];
    assign e_link     = rd_data[IW-1:0];
    assign e_match    = e_fix.valid && (e_fix.asid == r_asid) && (e_fix.vpage == r_vpage);

    assign new_fix    = '{valid: 1'b1, asid: r_asid, vpage: r_vpage, frame: r_frame};
    assign hash_key   = {{(KEY_W-ASID_W){1'b0}}, i_space_id} ^ i_virt_addr[VADDR_W-1 -: PAGE_W];

    hpt_head_index #(
        .HEAD_SLOTS (HEAD_SLOTS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_accept),
        .i_key   (hash_key),
        .o_done  (hash_done),
        .o_rem   (hash_rem)
    );

    hpt_mem #(
        .DEPTH (TABLE_SLOTS),
        .AW    (IW),
        .DW    (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and memory control
    always_comb begin
        n_state = r_state;
        wr_en   = 1'b0;
        wr_addr = r_cur;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = IW'(hash_rem);
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = IW'(r_clr);
                if (r_clr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    rd_en   = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                rd_addr = e_link;
                if (r_op == OP_LOOKUP) begin
                    if (e_match || !e_has_link) begin
                        n_state = S_DONE;
                    end else begin
                        rd_en = 1'b1;
                    end
                end else if (r_first && !e_fix.valid) begin
                    // empty head slot takes the mapping
                    wr_en   = 1'b1;
                    wr_addr = r_cur;
                    wr_data = {new_fix, 1'b0, {IW{1'b0}}};
                    n_state = S_DONE;
                end else if (e_has_link) begin
                    rd_en = 1'b1;
                end else if (ovf_full) begin
                    n_state = S_DONE;
                end else begin
                    // tail reached: fill the next overflow slot
                    wr_en   = 1'b1;
                    wr_addr = r_ovf[IW-1:0];
                    wr_data = {new_fix, 1'b0, {IW{1'b0}}};
                    n_state = S_LINK;
                end
            end
            S_LINK: begin
                wr_en   = 1'b1;
                wr_addr = r_cur;
                wr_data = {r_tail_fix, 1'b1, r_ovf[IW-1:0]};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // clear pointer and overflow fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_ovf <= OVF_BASE;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (r_state == S_LINK) begin
                r_ovf <= r_ovf + 1'b1;
            end
        end
    end

    // request latch and chain walk
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op    <= i_operation;
            r_asid  <= i_space_id;
            r_vpage <= i_virt_addr[VADDR_W-1 -: PAGE_W];
            r_frame <= i_new_frame;
        end
        if (r_state == S_HASH && hash_done) begin
            r_cur   <= IW'(hash_rem);
            r_first <= 1'b1;
        end
        if (r_state == S_CHECK) begin
            r_tail_fix <= e_fix;
            if (r_op == OP_LOOKUP) begin
                if (e_match) begin
                    r_res_status <= ST_OK;
                    r_res_frame  <= e_fix.frame;
                end else if (e_has_link) begin
                    r_cur   <= e_link;
                    r_first <= 1'b0;
                end else begin
                    r_res_status <= ST_MISS;
                    r_res_frame  <= '0;
                end
            end else if (r_first && !e_fix.valid) begin
                r_res_status <= ST_OK;
                r_res_frame  <= r_frame;
            end else if (e_has_link) begin
                r_cur   <= e_link;
                r_first <= 1'b0;
            end else if (ovf_full) begin
                r_res_status <= ST_FULL;
                r_res_frame  <= '0;
            end else begin
                r_res_status <= ST_OK;
                r_res_frame  <= r_frame;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_res_status;
            r_out_vpage  <= r_vpage;
            r_out_frame  <= r_res_frame;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_virt_page  = r_out_vpage;
    assign o_phys_frame = r_out_frame;

    // overflow fill count stays between HEAD_SLOTS and TABLE_SLOTS
    a_ovf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf >= OVF_BASE) && (r_ovf <= OVF_END))
        else $error("overflow fill count out of range");

    // a link write only follows an insert that reached the chain tail
    a_link_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |-> ($past(r_state) == S_CHECK) && (r_op == OP_INSERT))
        else $error("link write without a preceding tail allocation");

    // each allocation advances the fill count by one
    a_ovf_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINK) |=> (r_ovf == CW'($past(r_ovf) + 1'b1)))
        else $error("overflow fill count did not advance");

    // hash results arrive only while the controller waits for them
    a_hash_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> (r_state == S_HASH))
        else $error("hash result outside hash state");

endmodule

>>> test/hpt_checker.sv
// ---------------------------------------------------------------------------
// hpt_checker: translation predictor and result checker for the page table
// Watches the request and result channels. For every accepted request it
// works out the expected translation from its own copy of the table and
// compares each accepted result with the oldest one still owed.
// ---------------------------------------------------------------------------
module hpt_checker #(
    parameter int TABLE_SLOTS = hpt_pkg::TABLE_SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_operation,
    input  logic [hpt_pkg::ASID_W-1:0]  i_space_id,
    input  logic [hpt_pkg::VADDR_W-1:0] i_virt_addr,
    input  logic [hpt_pkg::PAGE_W-1:0]  i_new_frame,
    // result channel
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [hpt_pkg::STAT_W-1:0]  i_status,
    input  logic [hpt_pkg::PAGE_W-1:0]  i_virt_page,
    input  logic [hpt_pkg::PAGE_W-1:0]  i_phys_frame,
    // totals for the top
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_results,
    output int                          o_lookups,
    output int                          o_hits,
    output int                          o_misses,
    output int                          o_inserts,
    output int                          o_fulls,
    output int                          o_longest_walk
);
    timeunit 1ns;
    timeprecision 1ps;
    import hpt_pkg::*;

    localparam int HEAD_SLOTS = TABLE_SLOTS / 2;

    typedef struct packed {
        t_status           status;
        logic [PAGE_W-1:0] vpage;
        logic [PAGE_W-1:0] frame;
    } t_translation;

    // shadow copy of the page table
    logic              slot_used    [TABLE_SLOTS];
    logic [ASID_W-1:0] slot_asid    [TABLE_SLOTS];
    logic [PAGE_W-1:0] slot_vpage   [TABLE_SLOTS];
    logic [PAGE_W-1:0] slot_frame   [TABLE_SLOTS];
    logic              slot_chained [TABLE_SLOTS];
    int unsigned       slot_next    [TABLE_SLOTS];

    t_translation owed_translations [$];
    t_translation want;
    int fail_total;
    int result_total;
    int lookup_total;
    int hit_total;
    int miss_total;
    int insert_total;
    int full_total;
    int walk_max;
    int walk_len;

    function automatic void store_mapping(input int unsigned s, input logic [ASID_W-1:0] asid,
                                          input logic [PAGE_W-1:0] vpage,
                                          input logic [PAGE_W-1:0] frame);
        slot_used[s]    = 1'b1;
        slot_asid[s]    = asid;
        slot_vpage[s]   = vpage;
        slot_frame[s]   = frame;
        slot_chained[s] = 1'b0;
        slot_next[s]    = 0;
    endfunction

    // Lookup or insert against the shadow table; updates it on insert.
    function automatic t_translation translate(input logic op, input logic [ASID_W-1:0] asid,
                                               input logic [VADDR_W-1:0] vaddr,
                                               input logic [PAGE_W-1:0] frame);
        t_translation res;
        logic [PAGE_W-1:0] vpage;
        int unsigned cur;
        int unsigned steps;
        int unsigned s;
        bit free_found;
        vpage = vaddr[VADDR_W-1 -: PAGE_W];
        cur = ({{(PAGE_W-ASID_W){1'b0}}, asid} ^ vpage) % HEAD_SLOTS;
        res.status = ST_OK;
        res.vpage = vpage;
        res.frame = '0;
        steps = 0;
        if (op == OP_LOOKUP) begin
            // first matching valid entry along the chain wins
            res.status = ST_MISS;
            while (1'b1) begin
                if (slot_used[cur] && slot_asid[cur] == asid && slot_vpage[cur] == vpage) begin
                    res.status = ST_OK;
                    res.frame = slot_frame[cur];
                    break;
                end
                steps++;
                if (steps >= TABLE_SLOTS || !slot_chained[cur] || slot_next[cur] >= TABLE_SLOTS)
                    break;
                cur = slot_next[cur];
            end
        end else if (!slot_used[cur]) begin
            store_mapping(cur, asid, vpage, frame);
            res.frame = frame;
        end else begin
            // walk to the tail, then take the lowest free overflow slot
            steps = 1;
            while (steps < TABLE_SLOTS && slot_chained[cur] && slot_next[cur] < TABLE_SLOTS) begin
                cur = slot_next[cur];
                steps++;
            end
            free_found = 1'b0;
            for (s = HEAD_SLOTS; s < TABLE_SLOTS; s++) begin
                if (!slot_used[s]) begin
                    free_found = 1'b1;
                    break;
                end
            end
            if (!free_found) begin
                res.status = ST_FULL;
            end else begin
                store_mapping(s, asid, vpage, frame);
                slot_chained[cur] = 1'b1;
                slot_next[cur] = s;
                res.frame = frame;
            end
        end
        walk_len = steps;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                slot_used[s] = 1'b0;
                slot_chained[s] = 1'b0;
                slot_next[s] = 0;
            end
            owed_translations.delete();
            fail_total = 0;
            result_total = 0;
            lookup_total = 0;
            hit_total = 0;
            miss_total = 0;
            insert_total = 0;
            full_total = 0;
            walk_max = 0;
        end else begin
            // results first: a result on this edge belongs to an older request
            if (i_out_valid && !i_out_stall) begin
                result_total++;
                if (owed_translations.size() == 0) begin
                    $error("result with no request owed: status %0d page %h frame %h",
                           i_status, i_virt_page, i_phys_frame);
                    fail_total++;
                end else begin
                    want = owed_translations.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        fail_total++;
                    end
                    if (i_virt_page !== want.vpage) begin
                        $error("virt_page: expected %h, actual %h", want.vpage, i_virt_page);
                        fail_total++;
                    end
                    if (i_phys_frame !== want.frame) begin
                        $error("phys_frame: expected %h, actual %h", want.frame, i_phys_frame);
                        fail_total++;
                    end
                end
            end
            // new request
            if (i_in_valid && !i_in_stall) begin
                want = translate(i_operation, i_space_id, i_virt_addr, i_new_frame);
                owed_translations.push_back(want);
                if (walk_len > walk_max)
                    walk_max = walk_len;
                if (i_operation == OP_LOOKUP) begin
                    lookup_total++;
                    if (want.status == ST_OK)
                        hit_total++;
                    else
                        miss_total++;
                end else begin
                    insert_total++;
                    if (want.status == ST_FULL)
                        full_total++;
                end
            end
        end
        o_fail_count   <= fail_total;
        o_pending      <= owed_translations.size();
        o_results      <= result_total;
        o_lookups      <= lookup_total;
        o_hits         <= hit_total;
        o_misses       <= miss_total;
        o_inserts      <= insert_total;
        o_fulls        <= full_total;
        o_longest_walk <= walk_max;
    end

endmodule

>>> test/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for the chained hashed page table
// Drives directed then random lookups and inserts, clustered on a few head
// slots so chains grow long and the overflow area runs full, with random
// gaps and stalls on both sides; results are checked by hpt_checker.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hpt_pkg::*;

    localparam int TABLE_SLOTS    = TABLE_SLOTS_DEF;
    localparam int HEAD_SLOTS     = TABLE_SLOTS / 2;
    localparam int RANDOM_ITEMS   = 1380;
    localparam int HOT_HEADS      = 24;
    localparam int HOLD_AFTER     = 250;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 64;

    typedef struct packed {
        logic [ASID_W-1:0] asid;
        logic [PAGE_W-1:0] vpage;
    } t_mapping_key;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_operation;
    logic [ASID_W-1:0]  i_space_id;
    logic [VADDR_W-1:0] i_virt_addr;
    logic [PAGE_W-1:0]  i_new_frame;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [STAT_W-1:0]  o_status;
    logic [PAGE_W-1:0]  o_virt_page;
    logic [PAGE_W-1:0]  o_phys_frame;

    int fail_count;
    int pending_results;
    int results_seen;
    int lookup_count;
    int hit_count;
    int miss_count;
    int insert_count;
    int full_count;
    int longest_walk;

    t_mapping_key known_keys [$];
    int           hot_heads  [HOT_HEADS];
    int           requests_sent;
    bit           hold_done;

    hashed_page_table_chained #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_space_id   (i_space_id),
        .i_virt_addr  (i_virt_addr),
        .i_new_frame  (i_new_frame),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_virt_page  (o_virt_page),
        .o_phys_frame (o_phys_frame)
    );

    hpt_checker #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_translation_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_space_id     (i_space_id),
        .i_virt_addr    (i_virt_addr),
        .i_new_frame    (i_new_frame),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_virt_page    (o_virt_page),
        .i_phys_frame   (o_phys_frame),
        .o_fail_count   (fail_count),
        .o_pending      (pending_results),
        .o_results      (results_seen),
        .o_lookups      (lookup_count),
        .o_hits         (hit_count),
        .o_misses       (miss_count),
        .o_inserts      (insert_count),
        .o_fulls        (full_count),
        .o_longest_walk (longest_walk)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // mostly short idle spans, a few long ones
    function automatic int idle_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [PAGE_W-1:0] pick_frame();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return '0;
        else if (roll < 12)
            return '1;
        return PAGE_W'($urandom);
    endfunction

    // key whose hash lands on one of the few hot head slots
    function automatic t_mapping_key hot_key();
        t_mapping_key      k;
        logic [PAGE_W-1:0] low;
        logic [PAGE_W-1:0] mask;
        mask = PAGE_W'(HEAD_SLOTS - 1);
        k.asid = ASID_W'($urandom);
        low = PAGE_W'(hot_heads[$urandom_range(0, HOT_HEADS - 1)]) ^ PAGE_W'(k.asid);
        k.vpage = (PAGE_W'($urandom) & ~mask) | (low & mask);
        return k;
    endfunction

    function automatic logic [VADDR_W-1:0] page_addr(input t_mapping_key k);
        return {k.vpage, 12'($urandom)};
    endfunction

    // offer one transaction, wait for it to be taken, then maybe pause
    task automatic send_request(input logic op, input logic [ASID_W-1:0] asid,
                                input logic [VADDR_W-1:0] vaddr,
                                input logic [PAGE_W-1:0] frame);
        int gap;
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_space_id  <= asid;
        i_virt_addr <= vaddr;
        i_new_frame <= frame;
        do @(posedge i_clk); while (o_in_stall);
        requests_sent++;
        // every so often a back-to-back burst
        gap = ((requests_sent % 200) >= 170) ? 0 : idle_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result side: random stalls plus one long hold-off to back up the block
    initial begin
        int stall_len;
        int free_len;
        hold_done = 1'b0;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                stall_len = idle_length();
                if (stall_len > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (stall_len) @(posedge i_clk);
                end
            end
            free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 6);
            i_out_stall <= 1'b0;
            repeat (free_len) @(posedge i_clk);
        end
    end

    // watchdog on cycles without any accepted transaction
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // stimulus and verdict
    initial begin
        t_mapping_key key;
        int           roll;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_operation <= OP_LOOKUP;
        i_space_id  <= '0;
        i_virt_addr <= '0;
        i_new_frame <= '0;
        requests_sent = 0;
        hot_heads[0] = 0;
        hot_heads[1] = HEAD_SLOTS - 1;
        hot_heads[2] = HEAD_SLOTS / 2;
        for (int h = 3; h < HOT_HEADS; h++)
            hot_heads[h] = $urandom_range(0, HEAD_SLOTS - 1);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty table, frame zero, all-ones fields, collisions,
        // duplicate insert, mid-chain and tail hits, chain miss, last head slot
        send_request(OP_LOOKUP, 8'h00, 32'h0000_0000, 20'h00000);
        send_request(OP_INSERT, 8'h00, 32'h0000_0000, 20'h00000);
        send_request(OP_LOOKUP, 8'h00, 32'h0000_0FFF, 20'hFFFFF);
        send_request(OP_INSERT, 8'hFF, 32'hFFFF_FFFF, 20'hFFFFF);
        send_request(OP_LOOKUP, 8'hFF, 32'hFFFF_F000, 20'h00000);
        send_request(OP_INSERT, 8'h01, 32'h0000_1000, 20'hABCDE);
        send_request(OP_INSERT, 8'h80, 32'h0008_0000, 20'h13579);
        send_request(OP_INSERT, 8'h00, 32'h0000_0123, 20'h12345);
        send_request(OP_LOOKUP, 8'h00, 32'h0000_0000, 20'h00000);
        send_request(OP_LOOKUP, 8'h01, 32'h0000_1ABC, 20'h00000);
        send_request(OP_LOOKUP, 8'h80, 32'h0008_0FFF, 20'h00000);
        send_request(OP_LOOKUP, 8'h00, 32'h0020_0000, 20'h00000);
        send_request(OP_INSERT, 8'h00, 32'h001F_F000, 20'h0F0F0);
        send_request(OP_LOOKUP, 8'h00, 32'h001F_FABC, 20'h00000);
        send_request(OP_INSERT, 8'h01, 32'h001F_E000, 20'h70F0F);
        send_request(OP_LOOKUP, 8'h01, 32'h001F_E555, 20'h00000);
        send_request(OP_LOOKUP, 8'h5A, 32'h8000_0000, 20'h00000);

        // random: clustered inserts and lookups of known keys, plus noise
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 10) begin
                send_request(1'($urandom), ASID_W'($urandom), $urandom, pick_frame());
            end else if (roll < 64) begin
                if (known_keys.size() > 0 && $urandom_range(0, 9) == 0) begin
                    key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                end else begin
                    key = hot_key();
                    known_keys.push_back(key);
                end
                send_request(OP_INSERT, key.asid, page_addr(key), pick_frame());
            end else begin
                if (known_keys.size() > 0 && $urandom_range(0, 9) < 7)
                    key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                else
                    key = hot_key();
                send_request(OP_LOOKUP, key.asid, page_addr(key), pick_frame());
            end
        end

        // drain
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests: %0d lookups (%0d hits, %0d misses), %0d inserts",
                 requests_sent, lookup_count, hit_count, miss_count, insert_count);
        $display("Inserts refused on a full overflow area: %0d; longest chain walk: %0d entries",
                 full_count, longest_walk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> hashed_page_table_chained.f
rtl/hpt_pkg.sv
rtl/hpt_hash.sv
rtl/hpt_mem.sv
rtl/hashed_page_table_chained.sv
test/hpt_checker.sv
test/tb.sv
